// ===== src/mex_pkg.sv =====
// Package for the modular exponentiation block.
// Holds the operand width, the sequencer and operation codes and the
// request and response structs of the shared multiply-reduce unit.
package mex_pkg;

    // Operand width used by the arithmetic; ports stay at the field widths.
    localparam int OPERAND_BITS = 32;
    localparam int FIELD_W      = 32;
    localparam int EXP_W        = 63;
    // Effective modulus width: a zero modulus stands for 2^OPERAND_BITS.
    localparam int M_W          = OPERAND_BITS + 1;
    // Width of the doubled partial remainder plus the addend.
    localparam int T_W          = OPERAND_BITS + 2;
    localparam int CNT_W        = $clog2(OPERAND_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_NEXT
    } t_state;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQR
    } t_op;

    // Request to the multiply-reduce unit: product = a * b mod m, a below m.
    typedef struct packed {
        logic                    start;
        logic [OPERAND_BITS-1:0] a;
        logic [OPERAND_BITS-1:0] b;
        logic [M_W-1:0]          m;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic [OPERAND_BITS-1:0] product;
    } t_mul_rsp;

endpackage

// ===== src/mex_mulmod.sv =====
// Shift-add modular multiplier for the modular exponentiation block.
// Takes one multiplier bit per cycle, most significant first; uses mex_pkg.
module mex_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mex_pkg::t_mul_req  i_req,
    output mex_pkg::t_mul_rsp  o_rsp
);

    logic                             r_run;
    logic                             r_done;
    logic [mex_pkg::CNT_W-1:0]        r_cnt;
    logic [mex_pkg::OPERAND_BITS-1:0] r_a;
    logic [mex_pkg::OPERAND_BITS-1:0] r_b;
    logic [mex_pkg::M_W-1:0]          r_m;
    logic [mex_pkg::OPERAND_BITS-1:0] r_r;
    logic [mex_pkg::OPERAND_BITS-1:0] n_r;

    logic [mex_pkg::OPERAND_BITS-1:0] w_addend;
    logic [mex_pkg::T_W-1:0]          w_sum;
    logic [mex_pkg::T_W-1:0]          w_m1;
    logic [mex_pkg::T_W-1:0]          w_m2;
    logic [mex_pkg::T_W-1:0]          w_sel;

    // One step: double the remainder, add a if the bit is set, then bring
    // the sum (below three times m) back under m.
    always_comb begin
        w_addend = r_b[mex_pkg::OPERAND_BITS-1] ? r_a : '0;
        w_sum    = mex_pkg::T_W'({r_r, 1'b0}) + mex_pkg::T_W'(w_addend);
        w_m1     = mex_pkg::T_W'(r_m);
        w_m2     = {r_m, 1'b0};
        priority if (w_sum >= w_m2) begin
            w_sel = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_sel = w_sum - w_m1;
        end else begin
            w_sel = w_sum;
        end
        n_r = w_sel[mex_pkg::OPERAND_BITS-1:0];
    end

    // Control: run for one cycle per multiplier bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    // Operands and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
            r_r   <= '0;
            r_cnt <= mex_pkg::CNT_W'(mex_pkg::OPERAND_BITS - 1);
        end else if (r_run) begin
            r_r   <= n_r;
            r_b   <= {r_b[mex_pkg::OPERAND_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_r;

endmodule

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation, right-to-left square-and-multiply.
// A request runs a base reduction and then one modular multiplication
// per set exponent bit and one squaring per bit below the top set bit;
// worst case 126 passes through the unit, the reduction alone for a zero exponent.
// The shift-add multiply-reduce unit takes one multiplier bit a cycle;
// busy is high for the whole request. Synchronous reset idles the block.
module modular_exponentiation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_base,
    input  logic [62:0] i_exponent,
    input  logic [31:0] i_modulus,
    output logic        o_valid,
    output logic [31:0] o_power_result
);

    mex_pkg::t_state                  r_state;
    mex_pkg::t_state                  n_state;
    mex_pkg::t_op                     r_op;
    logic [mex_pkg::OPERAND_BITS-1:0] r_power;
    logic [mex_pkg::OPERAND_BITS-1:0] r_acc;
    logic [mex_pkg::EXP_W-1:0]        r_expo;
    logic [mex_pkg::M_W-1:0]          r_m;
    logic                             r_valid;

    logic [mex_pkg::OPERAND_BITS-1:0] w_base;
    logic [mex_pkg::OPERAND_BITS-1:0] w_mod_low;
    logic [mex_pkg::M_W-1:0]          w_m_in;
    logic [mex_pkg::OPERAND_BITS-1:0] w_one_mod;
    mex_pkg::t_mul_req                w_req;
    mex_pkg::t_mul_rsp                w_rsp;

    // Operand preparation; a zero modulus becomes 2^OPERAND_BITS.
    always_comb begin
        w_base    = i_base[mex_pkg::OPERAND_BITS-1:0];
        w_mod_low = i_modulus[mex_pkg::OPERAND_BITS-1:0];
        w_m_in    = {(w_mod_low == '0), w_mod_low};
        w_one_mod = mex_pkg::OPERAND_BITS'(w_m_in != mex_pkg::M_W'(1));
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mex_pkg::ST_IDLE: begin
                if (start) n_state = mex_pkg::ST_MUL;
            end
            mex_pkg::ST_MUL: begin
                if (w_rsp.done) n_state = mex_pkg::ST_NEXT;
            end
            mex_pkg::ST_NEXT: begin
                n_state = (r_expo == '0) ? mex_pkg::ST_IDLE : mex_pkg::ST_MUL;
            end
            default: n_state = mex_pkg::ST_IDLE;
        endcase
    end

    // Requests to the multiply-reduce unit.
    always_comb begin
        w_req.start = 1'b0;
        w_req.a     = r_power;
        w_req.b     = r_power;
        w_req.m     = r_m;
        unique case (r_state)
            mex_pkg::ST_IDLE: begin
                // Reduce the base first: base * (1 mod m).
                w_req.start = start;
                w_req.a     = w_one_mod;
                w_req.b     = w_base;
                w_req.m     = w_m_in;
            end
            mex_pkg::ST_NEXT: begin
                w_req.start = (r_expo != '0);
                w_req.b     = r_expo[0] ? r_acc : r_power;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    mex_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mex_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == mex_pkg::ST_NEXT) && (r_expo == '0);
        end
    end

    // Running values. A multiply clears the current exponent bit so the
    // squaring follows; a squaring shifts the exponent down.
    always_ff @(posedge i_clk) begin
        if ((r_state == mex_pkg::ST_IDLE) && start) begin
            r_expo <= i_exponent;
            r_m    <= w_m_in;
            r_acc  <= mex_pkg::OPERAND_BITS'(1);
            r_op   <= mex_pkg::OP_REDUCE;
        end else if ((r_state == mex_pkg::ST_MUL) && w_rsp.done) begin
            unique case (r_op)
                mex_pkg::OP_ACC: begin
                    r_acc     <= w_rsp.product;
                    r_expo[0] <= 1'b0;
                end
                mex_pkg::OP_SQR: begin
                    r_power <= w_rsp.product;
                    r_expo  <= r_expo >> 1;
                end
                default: begin
                    r_power <= w_rsp.product;
                end
            endcase
        end else if ((r_state == mex_pkg::ST_NEXT) && (r_expo != '0)) begin
            r_op <= r_expo[0] ? mex_pkg::OP_ACC : mex_pkg::OP_SQR;
        end
    end

    assign busy           = (r_state != mex_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_power_result = mex_pkg::FIELD_W'(r_acc);

    // The result strobe only appears once the sequencer is idle again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The unit only finishes while the sequencer waits for it.
    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == mex_pkg::ST_MUL))
        else $error("multiply finished outside the wait state");

    // Each product is fully reduced.
    a_product_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mex_pkg::ST_MUL) && w_rsp.done)
            |-> (mex_pkg::M_W'(w_rsp.product) < r_m))
        else $error("product not below modulus");

    // The strobe lasts exactly one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

// ===== tb/modular_exponentiation_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the modular exponentiation block.
// Predicts base^exponent mod modulus for every accepted request and compares it
// with each strobed result; depends on mex_pkg for the operand and field widths.
module modular_exponentiation_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [mex_pkg::FIELD_W-1:0] i_base,
    input  logic [mex_pkg::EXP_W-1:0]   i_exponent,
    input  logic [mex_pkg::FIELD_W-1:0] i_modulus,
    input  logic                       i_valid,
    input  logic [mex_pkg::FIELD_W-1:0] i_power_result,
    output int                         o_mismatches,
    output int                         o_checked,
    output int                         o_outstanding
);

    localparam logic [63:0] OPERAND_MASK = (64'd1 << mex_pkg::OPERAND_BITS) - 64'd1;
    localparam int          REPORT_LIMIT = 10;

    // One accepted request together with the power it must produce.
    typedef struct {
        logic [mex_pkg::FIELD_W-1:0] base;
        logic [mex_pkg::EXP_W-1:0]   exponent;
        logic [mex_pkg::FIELD_W-1:0] modulus;
        logic [mex_pkg::FIELD_W-1:0] power;
    } t_power_job;

    t_power_job pending_powers[$];
    t_power_job oldest_job;
    t_power_job incoming_job;
    int         mismatch_count;
    int         checked_count;
    int         outstanding_count;

    assign o_mismatches  = mismatch_count;
    assign o_checked     = checked_count;
    assign o_outstanding = outstanding_count;

    initial begin
        mismatch_count    = 0;
        checked_count     = 0;
        outstanding_count = 0;
    end

    // A zero modulus stands for 2^OPERAND_BITS, which keeps only the low bits.
    function automatic logic [63:0] reduce_by(input logic [63:0] value,
                                              input logic [63:0] modulus);
        if (modulus == 64'd0) begin
            return value & OPERAND_MASK;
        end
        return value % modulus;
    endfunction

    // Right-to-left square-and-multiply with full 64-bit products.
    function automatic logic [mex_pkg::FIELD_W-1:0] predict_power(
        input logic [mex_pkg::FIELD_W-1:0] base,
        input logic [mex_pkg::EXP_W-1:0]   exponent,
        input logic [mex_pkg::FIELD_W-1:0] modulus
    );
        logic [63:0]               squared;
        logic [63:0]               acc;
        logic [63:0]               mod_wide;
        logic [mex_pkg::EXP_W-1:0] bits_left;
        squared   = {32'd0, base} & OPERAND_MASK;
        mod_wide  = {32'd0, modulus} & OPERAND_MASK;
        bits_left = exponent;
        acc       = 64'd1;
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                acc = reduce_by(acc * squared, mod_wide);
            end
            squared   = reduce_by(squared * squared, mod_wide);
            bits_left = bits_left >> 1;
        end
        return acc[mex_pkg::FIELD_W-1:0];
    endfunction

    // Results are retired before new requests are queued, since a result can
    // never belong to the request accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (pending_powers.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected result %h with no request waiting",
                                 $realtime, i_power_result);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    oldest_job = pending_powers.pop_front();
                    checked_count <= checked_count + 1;
                    if (i_power_result !== oldest_job.power) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: mismatch base %h exp %h mod %h: expected %h, got %h",
                                     $realtime, oldest_job.base, oldest_job.exponent,
                                     oldest_job.modulus, oldest_job.power, i_power_result);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                incoming_job.base     = i_base;
                incoming_job.exponent = i_exponent;
                incoming_job.modulus  = i_modulus;
                incoming_job.power    = predict_power(i_base, i_exponent, i_modulus);
                pending_powers.push_back(incoming_job);
            end
        end
        outstanding_count <= pending_powers.size();
    end

endmodule

// ===== tb/modular_exponentiation_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the modular exponentiation block.
// Drives directed and random requests and gives the verdict; the result
// checking lives in modular_exponentiation_checker, widths come from mex_pkg.
module modular_exponentiation_tb;

    localparam int WATCHDOG_LIMIT   = 25000;
    localparam int DRAIN_CYCLES     = 4400;
    localparam int RANDOM_PER_PHASE = 41;
    localparam int MAX_GAP          = 30;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [mex_pkg::FIELD_W-1:0] i_base;
    logic [mex_pkg::EXP_W-1:0]   i_exponent;
    logic [mex_pkg::FIELD_W-1:0] i_modulus;
    logic                        o_valid;
    logic [mex_pkg::FIELD_W-1:0] o_power_result;

    int mismatches;
    int checked;
    int outstanding;
    int idle_pct;
    int requests_sent;
    int quiet_cycles;

    // 20 ns clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    modular_exponentiation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .o_valid        (o_valid),
        .o_power_result (o_power_result)
    );

    modular_exponentiation_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .i_valid        (o_valid),
        .i_power_result (o_power_result),
        .o_mismatches   (mismatches),
        .o_checked      (checked),
        .o_outstanding  (outstanding)
    );

    // Watchdog: ends the run when neither a request nor a result moves for too long.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $realtime, outstanding);
            $display("modular_exponentiation_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request after a random idle gap and holds it until accepted.
    // Called at a rising edge; returns at the edge that accepted the request.
    task automatic send_request(input logic [mex_pkg::FIELD_W-1:0] base,
                                input logic [mex_pkg::EXP_W-1:0]   exponent,
                                input logic [mex_pkg::FIELD_W-1:0] modulus);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        i_modulus  <= modulus;
        do begin
            @(posedge i_clk);
        end while (busy);
        requests_sent++;
    endtask

    // Field extremes, zero exponents and bases at or above the modulus.
    task automatic run_directed();
        send_request(32'd0,         63'd0,                    32'd1);
        send_request(32'hFFFF_FFFF, 63'd0,                    32'hFFFF_FFFF);
        send_request(32'd0,         63'd0,                    32'd7);
        send_request(32'd0,         63'd5,                    32'd7);
        send_request(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 63'd1,                    32'd7);
        send_request(32'd12,        63'd1,                    32'd12);
        send_request(32'd123456789, 63'h4000_0000_0000_0000, 32'd1000000007);
        send_request(32'd2,         63'h7FFF_FFFF_FFFF_FFFF, 32'd2);
        send_request(32'd3,         63'd5,                    32'd1);
        send_request(32'd1,         63'h5555_5555_5555_5555, 32'd13);
        send_request(32'd7,         63'h2AAA_AAAA_AAAA_AAAA, 32'h8000_0000);
        send_request(32'hFFFF_FFFF, 63'd2,                    32'h8000_0001);
        send_request(32'h0000_1234, 63'd10,                   32'd1000);
        send_request(32'd2,         63'd32,                   32'hFFFF_FFFB);
        send_request(32'hDEAD_BEEF, 63'd1,                    32'd1);
        send_request(32'd5,         63'd3,                    32'd2);
    endtask

    // Random operands; most exponents are at most 32 bits wide, to keep the run length sane.
    task automatic run_random_phase(input int count);
        logic [mex_pkg::FIELD_W-1:0] base;
        logic [mex_pkg::EXP_W-1:0]   exponent;
        logic [mex_pkg::FIELD_W-1:0] modulus;
        logic [63:0]                 wide;
        for (int n = 0; n < count; n++) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(9))
                0, 1, 2, 3: exponent = 63'($urandom_range(255));
                4, 5:       exponent = {31'd0, $urandom};
                default:    exponent = wide[62:0];
            endcase
            case ($urandom_range(7))
                0, 1:    modulus = $urandom_range(16, 1);
                2:       modulus = 32'hFFFF_FFFF - $urandom_range(15);
                3:       modulus = 32'd1 << $urandom_range(31);
                default: modulus = $urandom;
            endcase
            if (modulus == '0) begin
                modulus = 32'd1;
            end
            case ($urandom_range(7))
                0:       base = $urandom_range(1);
                1:       base = modulus - 32'd1 + $urandom_range(2);
                2:       base = 32'hFFFF_FFFF - $urandom_range(3);
                default: base = $urandom;
            endcase
            send_request(base, exponent, modulus);
        end
    endtask

    // Stimulus sequence and verdict.
    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_base        <= '0;
        i_exponent    <= '0;
        i_modulus     <= 32'd1;
        idle_pct      = 0;
        requests_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        idle_pct = 0;
        run_random_phase(RANDOM_PER_PHASE);
        idle_pct = 50;
        run_random_phase(RANDOM_PER_PHASE);
        idle_pct = 8;
        run_random_phase(RANDOM_PER_PHASE);

        // Let the last request settle into the checker, then drain.
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: directed extremes, zero exponents, random at 0/50/8%% idle.",
                 requests_sent);
        $display("Compared %0d results, %0d mismatches, %0d left outstanding.",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("modular_exponentiation_tb: PASS");
        end else begin
            $display("modular_exponentiation_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mex_pkg.sv
src/mex_mulmod.sv
src/modular_exponentiation.sv
tb/modular_exponentiation_checker.sv
tb/modular_exponentiation_tb.sv
